// ===== rtl/core/pds_pkg.sv =====
`timescale 1ns / 1ps

package pds_pkg;

	// operand widths
	localparam int FREQ_W   = 18;            // request in kHz
	localparam int FREF_W   = 8;             // reference in MHz
	localparam int DIV_W    = 18;            // divider dividend width
	localparam int DVSR_W   = 10;            // divider divisor width
	localparam int DCNT_W   = 5;             // divider step counter
	localparam int QTOT_W   = 8;             // total q, runs to one past the last
	localparam int DTOT_W   = 7;             // post divider scan value
	localparam int QA_W     = 16;            // whole MHz part of q*fout
	localparam int KRES_W   = 10;            // kHz remainder, below 1000
	localparam int FA_W     = 9;             // whole MHz part of fout
	localparam int PQ_W     = 23;            // running quotient m / fref
	localparam int PTOT_W   = 10;            // accepted total p
	localparam int RECIP_W  = 19;            // reciprocal of 1000
	localparam int RECIP_SH = 28;            // reciprocal scale, 2^28
	localparam int FMUL_W   = FREQ_W + RECIP_W;  // request times reciprocal

	// search constants
	localparam logic [DVSR_W-1:0] KHZ_PER_MHZ = 10'd1000;
	localparam logic [RECIP_W-1:0] MHZ_RECIP  = 19'd268436;  // ceil(2^28 / 1000)
	localparam logic [QTOT_W-1:0] Q_FIRST     = 8'd2;
	localparam logic [QTOT_W-1:0] Q_LAST      = 8'd129;
	localparam logic [DTOT_W-1:0] D_FIRST     = 7'd1;   // seed, one step before the scan
	localparam logic [DTOT_W-1:0] D_LAST      = 7'd127;
	localparam logic [PQ_W-1:0]   P_MIN       = 23'd16;
	localparam logic [PQ_W-1:0]   P_MAX       = 23'd1023;
	localparam logic [7:0]        DV_MAX      = 8'd127;
	localparam logic [8:0]        VCO_MIN     = 9'd100;
	localparam logic [8:0]        VCO_MAX     = 9'd400;

	// charge pump band limits on total p
	localparam logic [PTOT_W-1:0] PUMP_LIM0   = 10'd44;
	localparam logic [PTOT_W-1:0] PUMP_LIM1   = 10'd479;
	localparam logic [PTOT_W-1:0] PUMP_LIM2   = 10'd639;
	localparam logic [PTOT_W-1:0] PUMP_LIM3   = 10'd799;

	// source select codes
	localparam logic [1:0] SRC_DIRECT = 2'd1;
	localparam logic [1:0] SRC_DIV2   = 2'd2;
	localparam logic [1:0] SRC_DIV3   = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FDIV,
		ST_QNEXT,
		ST_QCHK,
		ST_QDIV,
		ST_STEP,
		ST_EVAL,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic div_start_f;   // take the request, scale it by 1/1000
		logic load_f;        // split fout into MHz and kHz, seed q
		logic next_q;        // advance q and q*fout
		logic div_start_a;   // divide q*fout/1000 by fref
		logic load_a;        // seed the post divider scan
		logic step;          // advance the post divider
		logic res_found;     // capture accepted settings
		logic res_zero;      // capture not found
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_busy;
		logic q_ok;
		logic cand;
		logic d_first;
		logic d_last;
		logic ok;
	} status_t;

endpackage

// ===== rtl/core/pds_divider.sv =====
`timescale 1ns / 1ps

module pds_divider
	import pds_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_W-1:0]  dividend,
	input  logic [DVSR_W-1:0] divisor,
	output logic              busy,
	output logic [DIV_W-1:0]  quotient,
	output logic [DVSR_W-1:0] remainder
);

	logic [DCNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DVSR_W-1:0] rem_q;
	logic [DVSR_W-1:0] dvsr_q;
	logic [DVSR_W:0]   shifted;
	logic              fits;

	// one quotient bit per cycle, restoring
	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign fits    = shifted >= {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DCNT_W'(DIV_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			dvsr_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? DVSR_W'(shifted - {1'b0, dvsr_q}) : shifted[DVSR_W-1:0];
		end
	end

	assign busy      = cnt_q != '0;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/core/pds_datapath.sv =====
`timescale 1ns / 1ps

module pds_datapath
	import pds_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output status_t           status,
	input  logic [FREQ_W-1:0] out_freq_khz,
	input  logic [FREF_W-1:0] fref,
	output logic              found,
	output logic [6:0]        q_count,
	output logic [9:0]        p_count,
	output logic              p_odd,
	output logic [6:0]        post_div,
	output logic [1:0]        clock_source,
	output logic [2:0]        pump_band
);

	// q loop: q*fout = qa*1000 + qb (kHz)
	logic [FA_W-1:0]   fa_q;
	logic [KRES_W-1:0] fb_q;
	logic [QTOT_W-1:0] q_q;
	logic [QA_W-1:0]   qa_q;
	logic [KRES_W-1:0] qb_q;
	// qa = adiv*fref + amod
	logic [QA_W-1:0]   adiv_q;
	logic [FREF_W-1:0] amod_q;
	// d loop: q*d*fout = m*1000 + r, m = pq*fref + pr
	logic [DTOT_W-1:0] d_q;
	logic [KRES_W-1:0] r_q;
	logic [PQ_W-1:0]   pq_q;
	logic [FREF_W-1:0] pr_q;

	logic              div_busy;
	logic [DIV_W-1:0]  div_quo;
	logic [DVSR_W-1:0] div_rem;
	logic [DIV_W-1:0]  div_dividend;
	logic [DVSR_W-1:0] div_divisor;

	// request split: fout/1000 by reciprocal multiply, exact below 2^18
	logic [FREQ_W-1:0] fin_q;
	logic [FMUL_W-1:0] fmul_q;
	logic [FA_W-1:0]   f_mhz;
	logic [FREQ_W-1:0] f_whole;
	logic [KRES_W-1:0] f_khz;

	always_ff @(posedge clk) begin
		if (cmd.div_start_f) begin
			fin_q  <= out_freq_khz;
			fmul_q <= FMUL_W'(out_freq_khz) * FMUL_W'(MHZ_RECIP);
		end
	end

	assign f_mhz   = fmul_q[RECIP_SH +: FA_W];
	assign f_whole = FREQ_W'(f_mhz) * FREQ_W'(KHZ_PER_MHZ);
	assign f_khz   = KRES_W'(fin_q - f_whole);

	assign div_dividend = DIV_W'(qa_q);
	assign div_divisor  = DVSR_W'(fref);

	pds_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start_a),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// next q: add fout in split form
	logic [KRES_W:0]   qb_sum;
	logic              qb_carry;
	assign qb_sum   = {1'b0, qb_q} + {1'b0, fb_q};
	assign qb_carry = qb_sum >= {1'b0, KHZ_PER_MHZ};

	// next d: add q*fout in split form, carry through both remainders
	logic [KRES_W:0]   r_sum;
	logic              r_carry;
	logic [FREF_W:0]   pr_sum;
	logic              pr_carry;
	assign r_sum    = {1'b0, r_q} + {1'b0, qb_q};
	assign r_carry  = r_sum >= {1'b0, KHZ_PER_MHZ};
	assign pr_sum   = {1'b0, pr_q} + {1'b0, amod_q} + (FREF_W+1)'(r_carry);
	assign pr_carry = pr_sum >= {1'b0, fref};

	always_ff @(posedge clk) begin
		if (cmd.load_f) begin
			fa_q <= f_mhz;
			fb_q <= f_khz;
			qa_q <= QA_W'(f_mhz);
			qb_q <= f_khz;
			q_q  <= Q_FIRST - 1'b1;
		end else if (cmd.next_q) begin
			qb_q <= qb_carry ? KRES_W'(qb_sum - {1'b0, KHZ_PER_MHZ}) : qb_sum[KRES_W-1:0];
			qa_q <= qa_q + QA_W'(fa_q) + QA_W'(qb_carry);
			q_q  <= q_q + 1'b1;
		end

		if (cmd.load_a) begin
			adiv_q <= div_quo[QA_W-1:0];
			amod_q <= div_rem[FREF_W-1:0];
			d_q    <= D_FIRST;
			r_q    <= qb_q;
			pq_q   <= PQ_W'(div_quo[QA_W-1:0]);
			pr_q   <= div_rem[FREF_W-1:0];
		end else if (cmd.step) begin
			d_q  <= d_q + 1'b1;
			r_q  <= r_carry ? KRES_W'(r_sum - {1'b0, KHZ_PER_MHZ}) : r_sum[KRES_W-1:0];
			pr_q <= pr_carry ? FREF_W'(pr_sum - {1'b0, fref}) : pr_sum[FREF_W-1:0];
			pq_q <= pq_q + PQ_W'(adiv_q) + PQ_W'(pr_carry);
		end
	end

	// candidate settings: p doubled once when it sits at the minimum
	logic                doubled;
	logic [PTOT_W-1:0]   p_tot;
	logic [7:0]          dv;
	logic [FREF_W+PTOT_W-1:0] vco;
	logic [QTOT_W+8:0]   vco_lo;
	logic [QTOT_W+8:0]   vco_hi;
	logic [2:0]          band;

	assign doubled = pq_q == P_MIN;
	assign p_tot   = doubled ? PTOT_W'(P_MIN << 1) : pq_q[PTOT_W-1:0];
	assign dv      = doubled ? {d_q, 1'b0} : {1'b0, d_q};
	assign vco     = (FREF_W+PTOT_W)'(fref) * (FREF_W+PTOT_W)'(p_tot);
	assign vco_lo  = (QTOT_W+9)'(VCO_MIN) * (QTOT_W+9)'(q_q);
	assign vco_hi  = (QTOT_W+9)'(VCO_MAX) * (QTOT_W+9)'(q_q);

	always_comb begin
		priority if (p_tot <= PUMP_LIM0) band = 3'd0;
		else if (p_tot <= PUMP_LIM1) band = 3'd1;
		else if (p_tot <= PUMP_LIM2) band = 3'd2;
		else if (p_tot <= PUMP_LIM3) band = 3'd3;
		else band = 3'd4;
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.res_found) begin
			found     <= 1'b1;
			q_count   <= 7'(q_q - Q_FIRST);
			p_count   <= 10'(p_tot[PTOT_W-1:1] - 9'd4);
			p_odd     <= p_tot[0];
			pump_band <= band;
			if (dv == 8'd2) begin
				post_div     <= 7'd4;
				clock_source <= SRC_DIV2;
			end else if (dv == 8'd3) begin
				post_div     <= 7'd6;
				clock_source <= SRC_DIV3;
			end else begin
				post_div     <= dv[6:0];
				clock_source <= SRC_DIRECT;
			end
		end else if (cmd.res_zero) begin
			found        <= 1'b0;
			q_count      <= '0;
			p_count      <= '0;
			p_odd        <= 1'b0;
			post_div     <= '0;
			clock_source <= '0;
			pump_band    <= '0;
		end
	end

	// status to the controller
	assign status.div_busy = div_busy;
	assign status.q_ok     = (q_q <= Q_LAST) && ({2'b00, q_q} <= {fref, 2'b00});
	assign status.cand     = (r_q == '0) && (pr_q == '0) && (pq_q >= P_MIN);
	assign status.d_first  = d_q == D_FIRST;
	assign status.d_last   = d_q == D_LAST;
	assign status.ok       = (dv <= DV_MAX) && (pq_q <= P_MAX)
		&& (vco >= (FREF_W+PTOT_W)'(vco_lo)) && (vco <= (FREF_W+PTOT_W)'(vco_hi));

endmodule

// ===== rtl/core/pds_ctrl.sv =====
`timescale 1ns / 1ps

module pds_ctrl
	import pds_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	output logic    done,
	output cmd_t    cmd,
	input  status_t status
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = state_q != ST_IDLE;
		done    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.div_start_f = 1'b1;
					state_d         = ST_FDIV;
				end
			end
			ST_FDIV: begin
				if (!status.div_busy) begin
					cmd.load_f = 1'b1;
					state_d    = ST_QNEXT;
				end
			end
			ST_QNEXT: begin
				cmd.next_q = 1'b1;
				state_d    = ST_QCHK;
			end
			ST_QCHK: begin
				if (status.q_ok) begin
					cmd.div_start_a = 1'b1;
					state_d         = ST_QDIV;
				end else begin
					cmd.res_zero = 1'b1;
					state_d      = ST_FINISH;
				end
			end
			ST_QDIV: begin
				if (!status.div_busy) begin
					cmd.load_a = 1'b1;
					state_d    = ST_STEP;
				end
			end
			ST_STEP: begin
				priority if (status.cand && !status.d_first) begin
					state_d = ST_EVAL;
				end else if (status.d_last) begin
					state_d = ST_QNEXT;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_EVAL: begin
				if (status.ok) begin
					cmd.res_found = 1'b1;
					state_d       = ST_FINISH;
				end else begin
					state_d = ST_QNEXT;
				end
			end
			ST_FINISH: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/pll_divider_search.sv =====
`timescale 1ns / 1ps

// PLL divider search.
// A request (out_freq_khz) is taken at a clock edge with start high and busy
// low. The block then scans total q from 2 and the post divider from 2 to 127
// for settings with fout = fref*p/(q*div) and a VCO of 100..400 MHz.
// The answer appears on found and the setting ports, marked by done for one
// cycle; the ports keep that word until the next answer. The receiver
// cannot stall, so done is never held off.
// The request is first split into MHz and kHz; then for each q value comes
// a q step, a q check and the serial division by fref, then the scan of
// divider values up to the first candidate, which is then checked.
// A zero reference fails the first q check and ends the search with found
// low; with no lock, q runs up to 129 or four times fref, the lower.
// busy stays high through done; the next request is taken the cycle after.
// The serial divider and the one-step-per-cycle scan set the search time.
// The reference frequency register is written over the cfg channel
// (cfg_valid, cfg_ready, cfg_data), which is always ready; write it only
// while busy is low. Reset returns the controller to idle and the
// reference register to 10 MHz.
module pll_divider_search
	import pds_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [FREQ_W-1:0] out_freq_khz,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [FREF_W-1:0] cfg_data,
	output logic              done,
	output logic              found,
	output logic [6:0]        q_count,
	output logic [9:0]        p_count,
	output logic              p_odd,
	output logic [6:0]        post_div,
	output logic [1:0]        clock_source,
	output logic [2:0]        pump_band
);

	logic [FREF_W-1:0] ref_freq_q;
	cmd_t              cmd;
	status_t           status;

	// reference frequency register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_freq_q <= 8'd10;
		end else if (cfg_valid && cfg_ready) begin
			ref_freq_q <= cfg_data;
		end
	end

	pds_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.status (status)
	);

	pds_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.out_freq_khz (out_freq_khz),
		.fref         (ref_freq_q),
		.found        (found),
		.q_count      (q_count),
		.p_count      (p_count),
		.p_odd        (p_odd),
		.post_div     (post_div),
		.clock_source (clock_source),
		.pump_band    (pump_band)
	);

endmodule

// ===== bench/pll_setting_checker.sv =====
`timescale 1ns / 1ps

module pll_setting_checker
	import pds_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [FREQ_W-1:0] out_freq_khz,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [FREF_W-1:0] cfg_data,
	input  logic              done,
	input  logic              found,
	input  logic [6:0]        q_count,
	input  logic [9:0]        p_count,
	input  logic              p_odd,
	input  logic [6:0]        post_div,
	input  logic [1:0]        clock_source,
	input  logic [2:0]        pump_band,
	output int                errors,
	output int                pending
);

	typedef struct packed {
		logic       found;
		logic [6:0] q_count;
		logic [9:0] p_count;
		logic       p_odd;
		logic [6:0] post_div;
		logic [1:0] clock_source;
		logic [2:0] pump_band;
	} pll_setting_t;

	pll_setting_t      setting_q[$];
	pll_setting_t      want;
	logic [FREF_W-1:0] fref_mhz;
	int                fail_count = 0;

	// first accepted (q, div) pair in scan order; all zero when none locks
	function automatic pll_setting_t search_setting(input logic [FREQ_W-1:0] fout,
			input logic [FREF_W-1:0] fref);
		longint unsigned f, r, qt, dt, prod, m, p, dv;
		pll_setting_t s;
		f = fout;
		r = fref;
		s = '0;
		for (qt = 2; qt < 130; qt++) begin
			// comparison frequency fref/q must stay at or above 0.25 MHz
			if (r * 4 < qt)
				break;
			for (dt = 2; dt < 128; dt++) begin
				prod = qt * dt * f;
				if (prod % 1000 != 0 || prod / 1000 <= 15 * r)
					continue;
				m = prod / 1000;
				if (m % r != 0)
					continue;
				p = m / r;
				dv = dt;
				// small p: double p and div until p passes 16
				while (p <= 16 && dv <= 127) begin
					p = p * 2;
					dv = dv * 2;
				end
				// a rejected candidate ends this q
				if (dv > 127 || p > 1023 || r * p < 100 * qt || r * p > 400 * qt)
					break;
				s.found = 1'b1;
				s.q_count = 7'(qt - 2);
				s.p_odd = p[0];
				s.p_count = 10'((p >> 1) - 4);
				case (dv)
					2: begin
						s.post_div = 7'd4;
						s.clock_source = SRC_DIV2;
					end
					3: begin
						s.post_div = 7'd6;
						s.clock_source = SRC_DIV3;
					end
					default: begin
						s.post_div = 7'(dv);
						s.clock_source = SRC_DIRECT;
					end
				endcase
				if (p <= 44)
					s.pump_band = 3'd0;
				else if (p <= 479)
					s.pump_band = 3'd1;
				else if (p <= 639)
					s.pump_band = 3'd2;
				else if (p <= 799)
					s.pump_band = 3'd3;
				else
					s.pump_band = 3'd4;
				return s;
			end
		end
		return s;
	endfunction

	task automatic check_field(input string name, input int unsigned exp_val,
			input int unsigned act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, actual %0d", name, exp_val, act_val);
			fail_count++;
		end
	endtask

	// request in, result word out, reference register writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fref_mhz = 8'd10;
			setting_q.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			if (start && !busy)
				setting_q.push_back(search_setting(out_freq_khz, fref_mhz));
			if (done) begin
				if (setting_q.size() == 0) begin
					$error("result word with no request waiting");
					fail_count++;
				end else begin
					want = setting_q.pop_front();
					check_field("found", want.found, found);
					check_field("q_count", want.q_count, q_count);
					check_field("p_count", want.p_count, p_count);
					check_field("p_odd", want.p_odd, p_odd);
					check_field("post_div", want.post_div, post_div);
					check_field("clock_source", want.clock_source, clock_source);
					check_field("pump_band", want.pump_band, pump_band);
				end
			end
			if (cfg_valid && cfg_ready)
				fref_mhz = cfg_data;
			errors <= fail_count;
			pending <= setting_q.size();
		end
	end

endmodule

// ===== bench/tb_pll_divider_search.sv =====
`timescale 1ns / 1ps

module tb_pll_divider_search
	import pds_pkg::*;
();

	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 10;
	localparam int DRAIN_CYCLES = 40;
	// ~100 requests, each a worst-case search plus a long gap, taken ~5x over
	localparam int unsigned CYCLE_LIMIT = 10_000_000;
	localparam int unsigned FREQ_TOP    = 262143;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [FREQ_W-1:0] out_freq_khz;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [FREF_W-1:0] cfg_data;
	logic              done;
	logic              found;
	logic [6:0]        q_count;
	logic [9:0]        p_count;
	logic              p_odd;
	logic [6:0]        post_div;
	logic [1:0]        clock_source;
	logic [2:0]        pump_band;
	int                errors;
	int                pending;
	bit                gaps_on;
	int unsigned       cycle_count;

	pll_divider_search DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.out_freq_khz (out_freq_khz),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.done         (done),
		.found        (found),
		.q_count      (q_count),
		.p_count      (p_count),
		.p_odd        (p_odd),
		.post_div     (post_div),
		.clock_source (clock_source),
		.pump_band    (pump_band)
	);

	pll_setting_checker CHK (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.out_freq_khz (out_freq_khz),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.done         (done),
		.found        (found),
		.q_count      (q_count),
		.p_count      (p_count),
		.p_odd        (p_odd),
		.post_div     (post_div),
		.clock_source (clock_source),
		.pump_band    (pump_band),
		.errors       (errors),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// run guard
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_pll_divider_search: FAIL");
		$finish;
	end

	// hold start until the request word is taken, then maybe idle a while
	task automatic send_request(input logic [FREQ_W-1:0] freq);
		int unsigned gap;
		start <= 1'b1;
		out_freq_khz <= freq;
		do @(posedge clk); while (busy);
		gap = 0;
		if (gaps_on)
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drop start and let every outstanding result come back
	task automatic wait_quiet();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
	endtask

	task automatic write_ref(input logic [FREF_W-1:0] value);
		wait_quiet();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// half the requests built from lockable settings, the rest round or raw values
	task automatic run_random_phase(input logic [FREF_W-1:0] fref, input int unsigned count);
		int unsigned kind, qt, dt, pt, lo, hi, qmax, a, b, t, g, cand;
		write_ref(fref);
		repeat (count) begin
			kind = $urandom_range(0, 9);
			cand = $urandom_range(1, 200) * 1000;
			if (kind < 5 && fref != 0) begin
				qmax = (fref * 4 < 129) ? fref * 4 : 129;
				qt = $urandom_range(2, qmax);
				dt = $urandom_range(2, 127);
				// p has to be a multiple of g for fref*p*1000/(q*div) to be whole
				a = qt * dt;
				b = fref * 1000;
				while (b != 0) begin
					t = a % b;
					a = b;
					b = t;
				end
				g = qt * dt / a;
				lo = (100 * qt + fref - 1) / fref;
				hi = 400 * qt / fref;
				if (lo < 16)
					lo = 16;
				if (hi > 1023)
					hi = 1023;
				lo = (lo + g - 1) / g;
				hi = hi / g;
				if (lo <= hi) begin
					pt = g * $urandom_range(lo, hi);
					t = fref * pt * 1000 / (qt * dt);
					if (t >= 1 && t <= FREQ_TOP)
						cand = t;
				end
			end else if (kind == 5) begin
				cand = $urandom_range(1, 800) * 250;
			end else if (kind == 6) begin
				cand = $urandom_range(1, 1600) * 125;
			end else if (kind == 8) begin
				cand = $urandom_range(0, FREQ_TOP);
			end else if (kind == 9) begin
				cand = $urandom_range(1, 200000);
			end
			send_request(cand[FREQ_W-1:0]);
			if ($urandom_range(0, 19) == 0)
				wait_quiet();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		out_freq_khz = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		gaps_on = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reference at its reset value of 10 MHz, no idling
		send_request(18'd0);         // zero request
		send_request(18'd262143);    // all ones
		send_request(18'd1);
		send_request(18'd1250);      // doubling pushes div past 127
		send_request(18'd35000);     // div 3, odd p
		send_request(18'd50000);     // div 2, lowest pump band
		send_request(18'd100000);
		send_request(18'd200000);
		send_request(18'd8000);
		send_request(18'd131072);
		send_request(18'd25000);

		// zero reference: nothing can lock
		write_ref(8'd0);
		send_request(18'd100000);

		// 1 MHz reference: large p, pump bands 1 to 4, p over 1023
		write_ref(8'd1);
		send_request(18'd260000);    // p over the counter range
		send_request(18'd200000);
		send_request(18'd199000);
		send_request(18'd150000);
		send_request(18'd100000);

		write_ref(8'd255);
		send_request(18'd200000);
		send_request(18'd1);
		send_request(18'd262143);

		// random phases over several reference settings
		for (int ph = 0; ph < 7; ph++) begin
			gaps_on = (ph % 3 != 0);
			case (ph)
				0: run_random_phase(8'd1, 15);
				1: run_random_phase(8'd255, 12);
				2: run_random_phase(8'($urandom_range(41, 255)), 14);
				default: run_random_phase(8'($urandom_range(2, 40)), 10);
			endcase
		end

		wait_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_pll_divider_search: PASS");
		else
			$display("tb_pll_divider_search: FAIL");
		$finish;
	end

endmodule
